FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the face key table.
// The macros expect a signal named clk in the scope where they are used; FKID_ASSERT_IMPLY also expects rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define FKID_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("face key table assertion failed");

// Next-cycle implication, also checked during reset.
`define FKID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("face key table assertion failed");

`endif

FILE: hw/rtl/fkid_pkg.sv
// Package for the face key to id table: sizes, codes, transaction types and helpers.
// Used by every module of the block but fkid_ram; depends on nothing else.
package fkid_pkg;

  // Table geometry. BUCKETS must be a power of two.
  localparam int BUCKETS     = 1024;
  localparam int WAYS        = 4;
  localparam int VERTEX_BITS = 32;
  localparam int DOF_BITS    = 16;

  localparam int BKT_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int FILL_W      = $clog2(WAYS + 1);
  localparam int ID_W        = 13;
  localparam int ID_LIMIT    = 8192;
  localparam int CNT_W       = 14;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request opcodes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  typedef logic [VERTEX_BITS-1:0] vertex_t;
  typedef vertex_t [3:0] key_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic                is_quad;
    vertex_t             vertex_a;
    vertex_t             vertex_b;
    vertex_t             vertex_c;
    vertex_t             vertex_d;
    logic [DOF_BITS-1:0] dof_number;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] face_id;
    logic [2:0]      status;
  } rsp_t;

  // Work class decided by the front part.
  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_LOOKUP,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                is_quad;
    key_t                verts;
    logic [DOF_BITS-1:0] dof;
    logic [BKT_W-1:0]    bucket;
  } cmd_t;

  // One way of a bucket; triangle entries leave the fourth vertex at zero.
  typedef struct packed {
    key_t                verts;
    logic [DOF_BITS-1:0] dof;
    logic [ID_W-1:0]     id;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;
  localparam int ROW_W = $bits(row_t);

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_REPORT
  } back_state_t;

  // Puts the vertices in ascending order; a triangle key has its fourth vertex zeroed.
  function automatic key_t sort_key(input key_t v, input logic quad);
    key_t    s;
    vertex_t t;
    s = v;
    if (quad) begin
      if (s[0] > s[1]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
      if (s[2] > s[3]) begin t = s[2]; s[2] = s[3]; s[3] = t; end
      if (s[0] > s[2]) begin t = s[0]; s[0] = s[2]; s[2] = t; end
      if (s[1] > s[3]) begin t = s[1]; s[1] = s[3]; s[3] = t; end
      if (s[1] > s[2]) begin t = s[1]; s[1] = s[2]; s[2] = t; end
    end else begin
      s[3] = '0;
      if (s[0] > s[1]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
      if (s[1] > s[2]) begin t = s[1]; s[1] = s[2]; s[2] = t; end
      if (s[0] > s[1]) begin t = s[0]; s[0] = s[1]; s[1] = t; end
    end
    return s;
  endfunction

  // XOR fold of the sorted key and the dof number down to a bucket number.
  function automatic logic [BKT_W-1:0] hash_bucket(input key_t v, input logic quad,
                                                   input logic [DOF_BITS-1:0] dof);
    logic [63:0] x;
    x = 64'(dof) ^ 64'(v[0]) ^ 64'(v[1]) ^ 64'(v[2]);
    if (quad) begin
      x = x ^ 64'(v[3]);
    end
    x = x ^ (x >> 32);
    x = x ^ (x >> 16);
    return x[BKT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/fkid_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for every table store of the face key table.
module fkid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/fkid_front.sv
// Front part of the face key table: classifies requests, sorts the key and hashes it.
// Depends on fkid_pkg.
module fkid_front (
  input  logic          req_valid,
  output logic          req_stall,
  input  fkid_pkg::req_t req_data,
  output logic          push,
  output fkid_pkg::cmd_t push_data,
  input  logic          full
);
  import fkid_pkg::*;

  key_t raw;
  key_t sorted;

  // A transaction is taken whenever the queue has room.
  assign req_stall = full;
  assign push      = req_valid && !full;

  // Canonical key and bucket.
  always_comb begin
    raw    = {req_data.vertex_d, req_data.vertex_c, req_data.vertex_b, req_data.vertex_a};
    sorted = sort_key(raw, req_data.is_quad);
    push_data.is_quad = req_data.is_quad;
    push_data.verts   = sorted;
    push_data.dof     = req_data.dof_number;
    push_data.bucket  = hash_bucket(sorted, req_data.is_quad, req_data.dof_number);
    unique case (req_data.opcode)
      OP_INSERT: push_data.kind = CMD_INSERT;
      OP_CLEAR:  push_data.kind = CMD_CLEAR;
      default:   push_data.kind = CMD_LOOKUP;
    endcase
  end

endmodule

FILE: hw/rtl/fkid_queue.sv
// Short command queue between the front and back parts of the face key table.
// Depends on fkid_pkg.
module fkid_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fkid_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output fkid_pkg::cmd_t pop_data,
  output logic           not_empty
);
  import fkid_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Payload slots need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/fkid_back.sv
// Back part of the face key table: bucket read, way compare, insert and clear sweep.
// Depends on fkid_pkg and fkid_ram.
module fkid_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  fkid_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output fkid_pkg::rsp_t rsp_data
);
  import fkid_pkg::*;

  back_state_t       state, state_next;
  cmd_t              cmd, cmd_next;
  logic [BKT_W-1:0]  sweep, sweep_next;
  logic              report_clear, report_clear_next;
  logic [CNT_W-1:0]  next_id, next_id_next;
  logic              rsp_valid_next;
  rsp_t              rsp_data_next;

  logic              rd_en;
  logic [BKT_W-1:0]  rd_addr;
  logic              tri_row_we, quad_row_we;
  logic              tri_fill_we, quad_fill_we;
  logic [BKT_W-1:0]  wr_addr;
  row_t              new_row;
  logic [FILL_W-1:0] fill_wdata;
  row_t              tri_row, quad_row, cur_row;
  logic [FILL_W-1:0] tri_fill, quad_fill, cur_fill;
  logic              hit;
  logic [ID_W-1:0]   hit_id;
  logic              out_free;
  entry_t            new_entry;

  // Bucket rows and fill counts of both tables.
  fkid_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_tri_rows (
    .clk, .we(tri_row_we), .waddr(wr_addr), .wdata(new_row),
    .re(rd_en), .raddr(rd_addr), .rdata(tri_row)
  );
  fkid_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_quad_rows (
    .clk, .we(quad_row_we), .waddr(wr_addr), .wdata(new_row),
    .re(rd_en), .raddr(rd_addr), .rdata(quad_row)
  );
  fkid_ram #(.WIDTH(FILL_W), .DEPTH(BUCKETS)) u_tri_fill (
    .clk, .we(tri_fill_we), .waddr(wr_addr), .wdata(fill_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(tri_fill)
  );
  fkid_ram #(.WIDTH(FILL_W), .DEPTH(BUCKETS)) u_quad_fill (
    .clk, .we(quad_fill_we), .waddr(wr_addr), .wdata(fill_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(quad_fill)
  );

  assign out_free = !rsp_valid || !rsp_stall;

  // Parallel compare of the valid ways and the row with the new entry added.
  always_comb begin
    cur_row  = cmd.is_quad ? quad_row : tri_row;
    cur_fill = cmd.is_quad ? quad_fill : tri_fill;
    hit      = 1'b0;
    hit_id   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if ((FILL_W'(w) < cur_fill) && (cur_row[w].dof == cmd.dof) &&
          (cur_row[w].verts[0] == cmd.verts[0]) && (cur_row[w].verts[1] == cmd.verts[1]) &&
          (cur_row[w].verts[2] == cmd.verts[2]) &&
          (!cmd.is_quad || (cur_row[w].verts[3] == cmd.verts[3]))) begin
        hit    = 1'b1;
        hit_id = cur_row[w].id;
      end
    end
    new_entry.verts = cmd.verts;
    new_entry.dof   = cmd.dof;
    new_entry.id    = next_id[ID_W-1:0];
    new_row = cur_row;
    for (int w = 0; w < WAYS; w++) begin
      if (FILL_W'(w) == cur_fill) begin
        new_row[w] = new_entry;
      end
    end
  end

  // Sequencer: next state, memory controls and the result register load.
  always_comb begin
    state_next        = state;
    cmd_next          = cmd;
    sweep_next        = sweep;
    report_clear_next = report_clear;
    next_id_next      = next_id;
    rsp_valid_next    = rsp_valid && rsp_stall;
    rsp_data_next     = rsp_data;
    q_pop             = 1'b0;
    rd_en             = 1'b0;
    rd_addr           = q_data.bucket;
    tri_row_we        = 1'b0;
    quad_row_we       = 1'b0;
    tri_fill_we       = 1'b0;
    quad_fill_we      = 1'b0;
    wr_addr           = cmd.bucket;
    fill_wdata        = cur_fill + 1'b1;
    unique case (state)
      BK_CLEAR: begin
        tri_fill_we  = 1'b1;
        quad_fill_we = 1'b1;
        wr_addr      = sweep;
        fill_wdata   = '0;
        sweep_next   = sweep + 1'b1;
        if (sweep == BKT_W'(BUCKETS - 1)) begin
          next_id_next = '0;
          state_next   = report_clear ? BK_REPORT : BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_next = q_data;
          if (q_data.kind == CMD_CLEAR) begin
            sweep_next        = '0;
            report_clear_next = 1'b1;
            state_next        = BK_CLEAR;
          end else begin
            rd_en      = 1'b1;
            state_next = BK_READ;
          end
        end
      end
      BK_READ: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          state_next     = BK_IDLE;
          if (hit) begin
            rsp_data_next = '{face_id: hit_id, status: ST_FOUND};
          end else if (cmd.kind != CMD_INSERT) begin
            rsp_data_next = '{face_id: '0, status: ST_NOT_FOUND};
          end else if ((cur_fill >= FILL_W'(WAYS)) || (next_id >= CNT_W'(ID_LIMIT))) begin
            rsp_data_next = '{face_id: '0, status: ST_FULL};
          end else begin
            rsp_data_next = '{face_id: next_id[ID_W-1:0], status: ST_INSERTED};
            next_id_next  = next_id + 1'b1;
            tri_row_we    = !cmd.is_quad;
            quad_row_we   = cmd.is_quad;
            tri_fill_we   = !cmd.is_quad;
            quad_fill_we  = cmd.is_quad;
          end
        end
      end
      BK_REPORT: begin
        if (out_free) begin
          rsp_valid_next    = 1'b1;
          rsp_data_next     = '{face_id: '0, status: ST_CLEARED};
          report_clear_next = 1'b0;
          state_next        = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Control registers; reset starts with a silent clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_CLEAR;
      sweep        <= '0;
      report_clear <= 1'b0;
      next_id      <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      sweep        <= sweep_next;
      report_clear <= report_clear_next;
      next_id      <= next_id_next;
      rsp_valid    <= rsp_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    rsp_data <= rsp_data_next;
  end

endmodule

FILE: hw/rtl/face_key_to_id_table.sv
// Face key to id table. Each request carries a triangle or quad key (vertex indices plus a
// dof number); the vertices are sorted, hashed to a bucket of a 4-way table and the ways
// compared, giving the stored id, a freshly assigned id, not found, or full (bucket full or
// ids used up). In the back part a lookup or insert is a registered bucket read, then the
// compare and write-back; it takes the next command only when done with the last one. A
// clear, and the start-up after reset, sweeps the fill counts of all 1024 buckets at one per
// cycle, and the back part takes no new work until the sweep is done; a clear's result
// follows the sweep. A two-entry queue lets requests be taken while the back part is busy.
// Depends on fkid_pkg, fkid_front, fkid_queue and fkid_back.
module face_key_to_id_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  fkid_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output fkid_pkg::rsp_t rsp_data
);
  import fkid_pkg::*;

  logic push, full, pop, not_empty;
  cmd_t push_data, pop_data;

  // Classify, sort and hash.
  fkid_front u_front (
    .req_valid, .req_stall, .req_data, .push, .push_data, .full
  );

  // Decoupling queue.
  fkid_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .pop_data, .not_empty
  );

  // Table access and result register.
  fkid_back u_back (
    .clk, .rst, .q_valid(not_empty), .q_data(pop_data), .q_pop(pop),
    .rsp_valid, .rsp_stall, .rsp_data
  );

endmodule

FILE: hw/rtl/fkid_checker.sv
// Port-level checks for the face key table, bound to the top level.
// Depends on fkid_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fkid_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input fkid_pkg::rsp_t rsp_data
);
  import fkid_pkg::*;

  logic no_entry;

  // Outcomes that name no stored entry.
  assign no_entry = (rsp_data.status == 3'(ST_NOT_FOUND)) || (rsp_data.status == 3'(ST_FULL)) ||
                    (rsp_data.status == 3'(ST_CLEARED));

  // A stalled result stays put.
  `FKID_ASSERT_NEXT(a_rsp_hold, !rst && rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
  // Reset leaves no result pending and the request side open.
  `FKID_ASSERT_NEXT(a_reset_empty, rst, !rsp_valid && !req_stall)
  // Only defined status codes come out.
  `FKID_ASSERT_IMPLY(a_status_code, rsp_valid, rsp_data.status <= 3'(ST_CLEARED))
  // Outcomes without an entry carry id zero.
  `FKID_ASSERT_IMPLY(a_zero_id, rsp_valid && no_entry, rsp_data.face_id == '0)

endmodule

bind face_key_to_id_table fkid_checker u_fkid_checker (
  .clk(clk), .rst(rst), .req_stall(req_stall), .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

FILE: dv/tb_face_key_to_id_table.sv
// Self-checking testbench for the face key to id table: a directed table, then random traffic.
// Depends on fkid_pkg and face_key_to_id_table; results are checked against a local model.
`timescale 1ns / 1ps

module tb_face_key_to_id_table;
  import fkid_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int N_RANDOM = 1430;
  localparam int POOL_N = 48;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  // Local copy of both tables and the shared id counter.
  key_t            mdl_keys [2][BUCKETS*WAYS];
  logic [15:0]     mdl_dof  [2][BUCKETS*WAYS];
  logic [ID_W-1:0] mdl_id   [2][BUCKETS*WAYS];
  int              mdl_fill [2][BUCKETS];
  int              mdl_next_id;

  rsp_t pending_rsp[$];
  int   err_count = 0;
  bit   stall_quiet = 1'b0;
  int   stall_left = 0;

  // Stimulus pools for keys that are reused so that lookups hit.
  key_t        pool_key [2][POOL_N];
  logic [15:0] pool_dof [2][POOL_N];

  typedef struct {
    req_t  req;
    bit    typed;
    rsp_t  rsp;
  } row_t_tb;

  row_t_tb rows[$];

  face_key_to_id_table dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
  );

  always #4 clk = ~clk;

  // Works out the result of one request and updates the local tables.
  function automatic rsp_t predict_face(req_t r);
    rsp_t        res;
    key_t        v;
    vertex_t     t;
    logic [63:0] x;
    int          n, q, b, cnt, e, j;
    bit          hit;
    res = '0;
    if (r.opcode == OP_CLEAR) begin
      foreach (mdl_fill[i, k]) mdl_fill[i][k] = 0;
      mdl_next_id = 0;
      res.status = ST_CLEARED;
      return res;
    end
    q = int'(r.is_quad);
    n = (q != 0) ? 4 : 3;
    v[0] = r.vertex_a; v[1] = r.vertex_b; v[2] = r.vertex_c;
    v[3] = (q != 0) ? r.vertex_d : '0;
    for (int i = 1; i < n; i++)
      for (j = i; j > 0 && v[j-1] > v[j]; j--) begin
        t = v[j-1]; v[j-1] = v[j]; v[j] = t;
      end
    x = 64'(r.dof_number);
    for (int i = 0; i < n; i++) x = x ^ 64'(v[i]);
    x = x ^ (x >> 32);
    x = x ^ (x >> 16);
    b = int'(x[15:0]) % BUCKETS;
    cnt = mdl_fill[q][b];
    for (int w = 0; w < cnt; w++) begin
      e = b * WAYS + w;
      hit = (mdl_dof[q][e] == r.dof_number);
      for (int k = 0; k < n; k++)
        if (mdl_keys[q][e][k] != v[k]) hit = 1'b0;
      if (hit) begin
        res.face_id = mdl_id[q][e];
        res.status = ST_FOUND;
        return res;
      end
    end
    if (r.opcode != OP_INSERT) begin
      res.status = ST_NOT_FOUND;
    end else if (cnt >= WAYS || mdl_next_id >= ID_LIMIT) begin
      res.status = ST_FULL;
    end else begin
      e = b * WAYS + cnt;
      mdl_keys[q][e] = v;
      mdl_dof[q][e] = r.dof_number;
      mdl_id[q][e] = mdl_next_id[ID_W-1:0];
      mdl_fill[q][b] = cnt + 1;
      res.face_id = mdl_next_id[ID_W-1:0];
      res.status = ST_INSERTED;
      mdl_next_id++;
    end
    return res;
  endfunction

  function automatic req_t make_req(logic [1:0] op, int quad, vertex_t a, vertex_t b,
                                    vertex_t c, vertex_t d, int dof);
    req_t r;
    r.opcode = op; r.is_quad = quad[0];
    r.vertex_a = a; r.vertex_b = b; r.vertex_c = c; r.vertex_d = d;
    r.dof_number = dof[15:0];
    return r;
  endfunction

  function automatic rsp_t make_rsp(int id, status_t st);
    rsp_t r;
    r.face_id = ID_W'(id);
    r.status = st;
    return r;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(req_t r, bit typed, rsp_t rsp);
    row_t_tb row;
    row.req = r;
    row.typed = typed;
    row.rsp = rsp;
    rows = {rows, row};
  endfunction

  // Random gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Builds a random request, mostly from the pools and same-bucket families.
  function automatic req_t random_req();
    req_t        r;
    key_t        k;
    vertex_t     t;
    logic [1:0]  op;
    int          sel, q, p, s1, s2, m;
    sel = $urandom_range(0, 99);
    m = $urandom_range(0, 9);
    op = (m < 6) ? OP_INSERT : (m < 9) ? OP_LOOKUP : OP_SPARE;
    q = $urandom_range(0, 1);
    if (sel < 2) begin
      return make_req(OP_CLEAR, q, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (sel < 62) begin
      p = $urandom_range(0, POOL_N - 1);
      k = pool_key[q][p];
      // Shuffle the vertex order; the key must still match.
      for (int i = 0; i < 3; i++) begin
        s1 = $urandom_range(0, (q != 0) ? 3 : 2);
        s2 = $urandom_range(0, (q != 0) ? 3 : 2);
        t = k[s1]; k[s1] = k[s2]; k[s2] = t;
      end
      if (q == 0) k[3] = $urandom;
      return make_req(op, q, k[0], k[1], k[2], k[3], int'(pool_dof[q][p]));
    end else if (sel < 82) begin
      // Pairs of equal vertices cancel in the hash, so each lands in the bucket given by its dof number.
      t = $urandom_range(0, 11);
      if (q != 0)
        return make_req(op, 1, t, t + 100, t, t + 100, $urandom_range(0, 3));
      return make_req(op, 0, t, 0, t, $urandom, $urandom_range(0, 3));
    end
    m = $urandom_range(0, 2);
    op = (m == 0) ? OP_INSERT : (m == 1) ? OP_LOOKUP : OP_SPARE;
    return make_req(op, q, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Offers one transaction and holds it until it is taken.
  task automatic send_req(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t pred;
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (req_stall);
    pred = predict_face(r);
    pending_rsp = {pending_rsp, (typed ? typed_rsp : pred)};
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    if (stall_quiet) begin
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      rsp_stall <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result transaction: face_id %0d status %0d",
               rsp_data.face_id, rsp_data.status);
        err_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_data.face_id !== exp_rsp.face_id) begin
          $error("face_id: expected %0d, actual %0d", exp_rsp.face_id, rsp_data.face_id);
          err_count++;
        end
        if (rsp_data.status !== exp_rsp.status) begin
          $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_data.status);
          err_count++;
        end
      end
    end
  end

  // Main stimulus sequence.
  initial begin
    rsp_t    none;
    int      waited;
    none = '0;
    mdl_next_id = 0;
    foreach (mdl_fill[i, k]) mdl_fill[i][k] = 0;
    for (int q = 0; q < 2; q++)
      for (int p = 0; p < POOL_N; p++) begin
        for (int k = 0; k < 4; k++)
          pool_key[q][p][k] = (p % 3 == 0) ? vertex_t'($urandom_range(0, 15)) : $urandom;
        pool_dof[q][p] = (p % 4 == 0) ? 16'hFFFF : 16'($urandom);
      end

    // Directed rows; typed results only where they are obvious.
    add_row(make_req(OP_LOOKUP, 0, 1, 2, 3, 0, 5), 1'b1, make_rsp(0, ST_NOT_FOUND));
    add_row(make_req(OP_INSERT, 0, 1, 2, 3, 9, 5), 1'b1, make_rsp(0, ST_INSERTED));
    add_row(make_req(OP_LOOKUP, 0, 3, 1, 2, 77, 5), 1'b1, make_rsp(0, ST_FOUND));
    add_row(make_req(OP_INSERT, 0, 2, 3, 1, 0, 5), 1'b1, make_rsp(0, ST_FOUND));
    add_row(make_req(OP_LOOKUP, 0, 1, 2, 3, 0, 6), 1'b1, make_rsp(0, ST_NOT_FOUND));
    add_row(make_req(OP_INSERT, 1, 10, 20, 30, 40, 0), 1'b1, make_rsp(1, ST_INSERTED));
    add_row(make_req(OP_SPARE, 1, 40, 30, 20, 10, 0), 1'b1, make_rsp(1, ST_FOUND));
    add_row(make_req(OP_SPARE, 1, 40, 30, 20, 11, 0), 1'b1, make_rsp(0, ST_NOT_FOUND));
    add_row(make_req(OP_INSERT, 0, '1, '1, '1, '1, 'hFFFF), 1'b0, none);
    add_row(make_req(OP_INSERT, 1, '1, '1, '1, '1, 'hFFFF), 1'b0, none);
    add_row(make_req(OP_INSERT, 1, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(make_req(OP_LOOKUP, 1, '1, '1, '1, '1, 'hFFFF), 1'b0, none);
    // Five keys that share one bucket: the fifth finds the bucket full.
    for (int k = 1; k <= 5; k++)
      add_row(make_req(OP_INSERT, 0, k, k, 0, 0, 7), 1'b0, none);
    add_row(make_req(OP_INSERT, 0, 6, 6, 0, 0, 7), 1'b1, make_rsp(0, ST_FULL));
    add_row(make_req(OP_LOOKUP, 0, 0, 2, 2, 0, 7), 1'b0, none);
    add_row(make_req(OP_CLEAR, 1, '1, '1, '1, '1, 'hFFFF), 1'b1, make_rsp(0, ST_CLEARED));
    add_row(make_req(OP_LOOKUP, 0, 1, 2, 3, 0, 5), 1'b1, make_rsp(0, ST_NOT_FOUND));
    add_row(make_req(OP_INSERT, 1, 10, 20, 30, 40, 0), 1'b1, make_rsp(0, ST_INSERTED));
    add_row(make_req(OP_INSERT, 0, 1, 2, 3, 0, 5), 1'b1, make_rsp(1, ST_INSERTED));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_req(rows[i].req, rows[i].typed, rows[i].rsp);
      idle_gap(pick_gap());
    end

    // Hold off until the block has drained once.
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      stall_quiet = (i >= 500 && i < 650);
      send_req(random_req(), 1'b0, none);
      if (i < 500 || i >= 650) idle_gap(pick_gap());
    end
    req_valid <= 1'b0;
    stall_quiet = 1'b0;

    waited = 0;
    while (pending_rsp.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_rsp.size() != 0) begin
      $error("%0d result transactions never arrived", pending_rsp.size());
      err_count++;
    end
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog.
  initial begin
    #8ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
